// ===== rtl/csrmv_pkg.sv =====
// Shared types and constants for the sparse CSR matrix-vector MAC.
// Used by every module of the block except csrmv_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package csrmv_pkg;

  localparam int CMD_W       = 2;
  localparam int COL_W       = 10;
  localparam int VAL_W       = 32;
  localparam int ACC_W       = 48;
  localparam int ROW_W       = 16;
  localparam int ADDR_EXT_W  = 17;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [VAL_W-1:0] OUT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] OUT_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD      = 2'd0,
    CMD_NONZERO   = 2'd1,
    CMD_EMPTY_ROW = 2'd2
  } cmd_t;

  // One classified operation handed from the front end to the back end.
  typedef struct packed {
    logic             empty_row;
    logic             row_end;
    logic             mat_end;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] vec_entry;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/csrmv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module csrmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/csrmv_front.sv =====
// Front end: accepts input beats, writes and reads the vector store, and
// pushes classified operations into the queue. Uses csrmv_pkg and csrmv_ram.
`timescale 1ns / 1ps
`default_nettype none

module csrmv_front #(
  parameter int VECTOR_DEPTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [csrmv_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [csrmv_pkg::COL_W-1:0]     in_col,
  input  wire logic [csrmv_pkg::VAL_W-1:0]     in_value,
  input  wire logic                            in_row_end,
  input  wire logic                            in_mat_end,
  input  wire logic [csrmv_pkg::LEVEL_W-1:0]   q_level,
  output logic                                 push,
  output csrmv_pkg::op_t                       push_op
);

  localparam int AW = $clog2(VECTOR_DEPTH);

  logic                                  accept;
  logic [csrmv_pkg::ADDR_EXT_W-1:0]      col_ext;
  logic [AW-1:0]                         addr;
  logic                                  in_range;
  logic                                  is_load;
  logic                                  is_nonzero;
  logic                                  is_empty;
  logic [csrmv_pkg::VAL_W-1:0]           ram_rdata;

  logic                                  f1_valid_r;
  logic                                  f1_empty_r;
  logic                                  f1_row_end_r;
  logic                                  f1_mat_end_r;
  logic                                  f1_in_range_r;
  logic [csrmv_pkg::VAL_W-1:0]           f1_value_r;

  assign in_ready = (csrmv_pkg::LEVEL_W'(q_level) + csrmv_pkg::LEVEL_W'(f1_valid_r))
                    < csrmv_pkg::LEVEL_W'(csrmv_pkg::QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  assign col_ext  = csrmv_pkg::ADDR_EXT_W'(in_col);
  assign addr     = col_ext[AW-1:0];
  assign in_range = col_ext < csrmv_pkg::ADDR_EXT_W'(VECTOR_DEPTH);

  always_comb begin
    is_load    = 1'b0;
    is_nonzero = 1'b0;
    is_empty   = 1'b0;
    unique case (in_cmd)
      csrmv_pkg::CMD_LOAD:      is_load    = 1'b1;
      csrmv_pkg::CMD_NONZERO:   is_nonzero = 1'b1;
      csrmv_pkg::CMD_EMPTY_ROW: is_empty   = 1'b1;
      default: ;
    endcase
  end

  csrmv_ram #(
    .WIDTH (csrmv_pkg::VAL_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk     (clk),
    .wr_en   (accept && is_load && in_range),
    .wr_addr (addr),
    .wr_data (in_value),
    .rd_en   (accept && is_nonzero),
    .rd_addr (addr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= accept && (is_nonzero || is_empty);
    end
    if (accept) begin
      f1_empty_r    <= is_empty;
      f1_row_end_r  <= in_row_end;
      f1_mat_end_r  <= in_mat_end;
      f1_in_range_r <= in_range;
      f1_value_r    <= in_value;
    end
  end

  assign push              = f1_valid_r;
  assign push_op.empty_row = f1_empty_r;
  assign push_op.row_end   = f1_row_end_r;
  assign push_op.mat_end   = f1_mat_end_r;
  assign push_op.value     = f1_value_r;
  assign push_op.vec_entry = (f1_in_range_r && !f1_empty_r) ? ram_rdata
                                                            : '0;

endmodule

`default_nettype wire

// ===== rtl/csrmv_queue.sv =====
// Short operation queue between the front end and the back end.
// Uses csrmv_pkg for the operation type and the depth.
`timescale 1ns / 1ps
`default_nettype none

module csrmv_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire csrmv_pkg::op_t                push_op,
  input  wire logic                          pop,
  output logic                               q_valid,
  output csrmv_pkg::op_t                     q_op,
  output logic [csrmv_pkg::LEVEL_W-1:0]      q_level
);

  csrmv_pkg::op_t                    store_r [csrmv_pkg::QUEUE_DEPTH];
  logic [csrmv_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [csrmv_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [csrmv_pkg::LEVEL_W-1:0]     level_r;
  logic [csrmv_pkg::LEVEL_W-1:0]     level_nxt;
  logic                              do_pop;

  assign do_pop = pop && (level_r != '0);

  always_comb begin
    level_nxt = level_r;
    if (push && !do_pop) begin
      level_nxt = level_r + csrmv_pkg::LEVEL_W'(1);
    end else if (!push && do_pop) begin
      level_nxt = level_r - csrmv_pkg::LEVEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + csrmv_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + csrmv_pkg::QPTR_W'(1);
      end
      level_r <= level_nxt;
    end
    if (push) begin
      store_r[wr_ptr_r] <= push_op;
    end
  end

  assign q_valid = (level_r != '0);
  assign q_op    = store_r[rd_ptr_r];
  assign q_level = level_r;

endmodule

`default_nettype wire

// ===== rtl/csrmv_back.sv =====
// Back end: multiplies, accumulates with saturation, and holds the result
// beat in an output register. Uses csrmv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csrmv_back #(
  parameter int MAX_ROWS = 65536
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire csrmv_pkg::op_t                q_op,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [csrmv_pkg::VAL_W-1:0]        out_row_sum,
  output logic [csrmv_pkg::ROW_W-1:0]        out_row_number,
  output logic                               out_last
);

  logic                              advance;
  logic signed [2*csrmv_pkg::VAL_W-1:0] prod;

  logic                              b1_valid_r;
  logic                              b1_empty_r;
  logic                              b1_row_end_r;
  logic                              b1_mat_end_r;
  logic [csrmv_pkg::ACC_W-1:0]       b1_prod_r;

  logic [csrmv_pkg::ACC_W-1:0]       acc_r;
  logic [csrmv_pkg::ACC_W-1:0]       acc_nxt;
  logic [csrmv_pkg::ACC_W:0]         sum_wide;
  logic [csrmv_pkg::ACC_W-1:0]       sum_sat;
  logic [csrmv_pkg::VAL_W-1:0]       sum_out;
  logic                              emit;
  logic [csrmv_pkg::ROW_W-1:0]       row_cnt_r;
  logic [csrmv_pkg::ROW_W-1:0]       row_cnt_nxt;
  logic [csrmv_pkg::ROW_W:0]         row_inc;
  logic                              out_valid_r;
  logic [csrmv_pkg::VAL_W-1:0]       out_sum_r;
  logic [csrmv_pkg::ROW_W-1:0]       out_row_r;
  logic                              out_last_r;

  assign advance = !out_valid_r || out_ready;
  assign pop     = advance && q_valid;
  assign prod    = $signed(q_op.value) * $signed(q_op.vec_entry);

  assign sum_wide = {b1_prod_r[csrmv_pkg::ACC_W-1], b1_prod_r}
                  + {acc_r[csrmv_pkg::ACC_W-1], acc_r};

  always_comb begin
    if (sum_wide[csrmv_pkg::ACC_W] != sum_wide[csrmv_pkg::ACC_W-1]) begin
      sum_sat = sum_wide[csrmv_pkg::ACC_W] ? csrmv_pkg::ACC_MIN : csrmv_pkg::ACC_MAX;
    end else begin
      sum_sat = sum_wide[csrmv_pkg::ACC_W-1:0];
    end
    if ((&sum_sat[csrmv_pkg::ACC_W-1:csrmv_pkg::VAL_W-1]) ||
        !(|sum_sat[csrmv_pkg::ACC_W-1:csrmv_pkg::VAL_W-1])) begin
      sum_out = sum_sat[csrmv_pkg::VAL_W-1:0];
    end else begin
      sum_out = sum_sat[csrmv_pkg::ACC_W-1] ? csrmv_pkg::OUT_MIN : csrmv_pkg::OUT_MAX;
    end
  end

  assign emit    = b1_empty_r || b1_row_end_r;
  assign row_inc = {1'b0, row_cnt_r} + (csrmv_pkg::ROW_W+1)'(1);

  always_comb begin
    acc_nxt     = acc_r;
    row_cnt_nxt = row_cnt_r;
    if (advance && b1_valid_r) begin
      if (!b1_empty_r) begin
        acc_nxt = b1_row_end_r ? '0 : sum_sat;
      end
      if (emit) begin
        if (b1_mat_end_r || (row_inc >= (csrmv_pkg::ROW_W+1)'(MAX_ROWS))) begin
          row_cnt_nxt = '0;
        end else begin
          row_cnt_nxt = row_inc[csrmv_pkg::ROW_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      row_cnt_r   <= '0;
    end else begin
      acc_r     <= acc_nxt;
      row_cnt_r <= row_cnt_nxt;
      if (advance) begin
        b1_valid_r  <= q_valid;
        out_valid_r <= b1_valid_r && emit;
      end
    end
    if (pop) begin
      b1_empty_r   <= q_op.empty_row;
      b1_row_end_r <= q_op.row_end;
      b1_mat_end_r <= q_op.mat_end;
      b1_prod_r    <= prod[2*csrmv_pkg::VAL_W-1:16];
    end
    if (advance && b1_valid_r && emit) begin
      out_sum_r  <= b1_empty_r ? '0 : sum_out;
      out_row_r  <= row_cnt_r;
      out_last_r <= b1_mat_end_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_sum    = out_sum_r;
  assign out_row_number = out_row_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/sparse_csr_matvec_mac.sv =====
// Sparse CSR matrix times dense vector, Q16.16 multiply-accumulate.
// Top level; uses csrmv_pkg, csrmv_front, csrmv_queue and csrmv_back.
//
// Usage:
//   Input beats on in_*: load vector entries first (cmd load), then stream
//   the nonzeros row by row (cmd nonzero, tlast on the last of a row), or
//   an empty-row beat for a row with no nonzeros. tuser bit 2 on a row end
//   marks the final matrix row.
//   Result beats on out_*: one per finished row, with the saturated sum,
//   the row number and tlast on the final row.
// Path: front stage, queue, back-end product stage, then the result register.
// Throughput: one input beat per cycle while no stall holds it, set by the
//   single multiplier and accumulator of the back end; a vector load written
//   in one cycle is seen by a nonzero accepted in the next.
// Reset: synchronous, active low; clears the accumulator, the row counter,
//   valid flags, queue pointers and level; the vector store is not cleared.
// Stall: while a result waits with out_tready low, the result register and
//   back end hold, the 4-entry queue fills and in_tready drops once the queue
//   and the front stage together hold 4 operations.
`timescale 1ns / 1ps
`default_nettype none

module sparse_csr_matvec_mac #(
  parameter int VECTOR_DEPTH = 1024,
  parameter int MAX_ROWS     = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // col_index[9:0], value[41:10], zero pad
  input  wire logic        in_tlast,   // row_end
  input  wire logic [2:0]  in_tuser,   // cmd[1:0], matrix_end[2]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // row_sum[31:0], row_number[47:32]
  output logic             out_tlast   // last_row
);

  logic                                push;
  csrmv_pkg::op_t                      push_op;
  logic                                pop;
  logic                                q_valid;
  csrmv_pkg::op_t                      q_op;
  logic [csrmv_pkg::LEVEL_W-1:0]       q_level;
  logic [csrmv_pkg::VAL_W-1:0]         row_sum;
  logic [csrmv_pkg::ROW_W-1:0]         row_number;

  csrmv_front #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser[1:0]),
    .in_col     (in_tdata[9:0]),
    .in_value   (in_tdata[41:10]),
    .in_row_end (in_tlast),
    .in_mat_end (in_tuser[2]),
    .q_level    (q_level),
    .push       (push),
    .push_op    (push_op)
  );

  csrmv_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_level (q_level)
  );

  csrmv_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_op           (q_op),
    .pop            (pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_row_sum    (row_sum),
    .out_row_number (row_number),
    .out_last       (out_tlast)
  );

  assign out_tdata = {row_number, row_sum};

endmodule

`default_nettype wire
